// File: hw/rtl/dfsr_pkg.sv
// Package with the shared types and constants of the dual-feed sequence reorder block.
package dfsr_pkg;

    localparam int SLOTS = 32;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int WIN_W = 7;
    localparam logic [5:0] WINDOW_RESET = 6'd32;

    localparam logic [1:0] ST_HEALTHY = 2'd0;
    localparam logic [1:0] ST_GAP     = 2'd1;
    localparam logic [1:0] ST_STALE   = 2'd2;
    localparam logic [1:0] ST_RECOVER = 2'd3;

    localparam logic CMD_EVENT    = 1'b0;
    localparam logic CMD_SNAPSHOT = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] session_id;
        logic        channel;
        logic [63:0] event_seq;
        logic [7:0]  event_type;
        logic [31:0] payload_ref;
        logic        last_in_packet;
    } t_in_item;

    typedef struct packed {
        logic        has_event;
        logic [63:0] out_seq;
        logic [7:0]  out_type;
        logic [31:0] out_payload_ref;
        logic        out_channel;
        logic [1:0]  feed_state;
        logic [63:0] gap_first;
        logic [63:0] gap_bound;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [63:0] seq;
        logic [7:0]  typ;
        logic [31:0] pay;
        logic        feed;
    } t_slot;

endpackage

// File: hw/rtl/dfsr_slot_ram.sv
// Slot storage: one write port and one registered read port.
module dfsr_slot_ram import dfsr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_slot            i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_slot            o_rdata
);

    t_slot r_mem [SLOTS];
    t_slot r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// File: hw/rtl/dual_feed_sequence_reorder.sv
// Top level of the dual-feed sequence reorder block.
// Usage: items enter on the input channel (i_in_valid, i_in_data, o_in_stall) and
// results leave on the output channel (o_out_valid, o_out_data, i_out_stall). An
// input transfer happens when valid is high and stall is low. Every input item
// yields zero or more emitted events followed by one status result with last set.
// window_limit is written through i_cfg_we / i_cfg_wdata. The user must write it only
// while the block is idle; the block itself does not enforce this. A slot scan reads the
// slot RAM one entry per cycle. An in-window feed event goes through a check state, one
// scan to find its slot and a write state; if it ends a packet, it then takes one scan per
// emitted event plus one final scan. A snapshot takes a clearing scan plus the same
// emission scans. The block stalls its input for the whole item, so it takes no new item
// before it has finished the last one.
// Reset: synchronous active-low i_rst_n empties all slots, clears sequence,
// session and gap state, and sets window_limit to 32.
// When the receiver stalls, the result holds in the output register and the
// sequencer waits before producing the next result.
module dual_feed_sequence_reorder import dfsr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall,
    input  logic      i_cfg_we,
    input  logic [5:0] i_cfg_wdata
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_SCAN  = 6'b000100,
        S_WRITE = 6'b001000,
        S_EDEC  = 6'b010000,
        S_STAT  = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        M_BUF  = 2'd0,
        M_SNAP = 2'd1,
        M_EMIT = 2'd2
    } t_mode;

    t_state          r_state;
    t_mode           r_mode;
    t_in_item        r_item;
    logic [5:0]      r_win;
    logic [63:0]     r_ne;
    logic [31:0]     r_session;
    logic [1:0]      r_health;
    logic [63:0]     r_gap_low;
    logic [63:0]     r_gap_high;
    logic [SLOTS-1:0] r_slot_valid;

    logic [CNT_W-1:0] r_cnt;
    logic             r_pv;
    logic [IDX_W-1:0] r_pidx;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;
    logic             r_any;
    logic [63:0]      r_lo;
    t_slot            r_hdata;

    logic      r_ov;
    t_out_item r_out;

    t_slot      ram_q;
    logic       ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_slot      ram_wdata;

    logic        out_free;
    logic        out_load;
    logic [63:0] ne_eff;
    logic [63:0] seq_diff;
    logic [WIN_W-1:0] win;
    logic [63:0] n_ne;
    logic        scan_done;

    assign out_free  = !r_ov || !i_out_stall;
    assign out_load  = out_free && ((r_state == S_STAT) || (r_state == S_EDEC && r_hit));
    assign ne_eff    = (r_ne == 64'd0) ? r_item.event_seq : r_ne;
    assign seq_diff  = r_item.event_seq - ne_eff;
    assign win       = ({1'b0, r_win} > WIN_W'(SLOTS)) ? WIN_W'(SLOTS) : {1'b0, r_win};
    assign n_ne      = r_ne + 64'd1;
    assign scan_done = (r_cnt == CNT_W'(SLOTS)) && !r_pv;

    assign ram_we    = (r_state == S_WRITE) && (r_hit || r_free);
    assign ram_waddr = r_hit ? r_hit_idx : r_free_idx;
    assign ram_wdata = '{seq: r_item.event_seq, typ: r_item.event_type,
                         pay: r_item.payload_ref, feed: r_item.channel};

    dfsr_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (ram_q)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= M_BUF;
            r_win        <= WINDOW_RESET;
            r_ne         <= '0;
            r_session    <= '0;
            r_health     <= ST_HEALTHY;
            r_gap_low    <= '0;
            r_gap_high   <= '0;
            r_slot_valid <= '0;
            r_cnt        <= '0;
            r_pv         <= 1'b0;
            r_hit        <= 1'b0;
            r_free       <= 1'b0;
            r_any        <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_win <= i_cfg_wdata;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end

            r_pv   <= (r_state == S_SCAN) && (r_cnt < CNT_W'(SLOTS));
            r_pidx <= r_cnt[IDX_W-1:0];

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_cnt  <= '0;
                    r_hit  <= 1'b0;
                    r_free <= 1'b0;
                    r_any  <= 1'b0;
                    if (r_item.cmd == CMD_SNAPSHOT) begin
                        r_ne     <= r_item.event_seq + 64'd1;
                        r_health <= ST_RECOVER;
                        r_mode   <= M_SNAP;
                        r_state  <= S_SCAN;
                    end else if (r_session != 32'd0 && r_item.session_id != r_session) begin
                        r_health <= ST_STALE;
                        r_state  <= S_STAT;
                    end else begin
                        r_session <= (r_session == 32'd0) ? r_item.session_id : r_session;
                        r_ne      <= ne_eff;
                        if (r_item.event_seq < ne_eff) begin
                            r_mode  <= r_item.last_in_packet ? M_EMIT : M_BUF;
                            r_state <= r_item.last_in_packet ? S_SCAN : S_STAT;
                        end else if (seq_diff >= {{(64-WIN_W){1'b0}}, win}) begin
                            r_health <= ST_GAP;
                            r_mode   <= r_item.last_in_packet ? M_EMIT : M_BUF;
                            r_state  <= r_item.last_in_packet ? S_SCAN : S_STAT;
                        end else begin
                            r_mode  <= M_BUF;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_cnt < CNT_W'(SLOTS)) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (r_pv && r_slot_valid[r_pidx]) begin
                        case (r_mode)
                            M_BUF: begin
                                if (ram_q.seq == r_item.event_seq && !r_hit) begin
                                    r_hit     <= 1'b1;
                                    r_hit_idx <= r_pidx;
                                end
                            end
                            M_SNAP: begin
                                if (ram_q.seq <= r_item.event_seq) begin
                                    r_slot_valid[r_pidx] <= 1'b0;
                                end
                            end
                            default: begin
                                if (ram_q.seq == r_ne && !r_hit) begin
                                    r_hit     <= 1'b1;
                                    r_hit_idx <= r_pidx;
                                    r_hdata   <= ram_q;
                                end
                                if (!r_any || ram_q.seq < r_lo) begin
                                    r_lo <= ram_q.seq;
                                end
                                r_any <= 1'b1;
                            end
                        endcase
                    end else if (r_pv && !r_free) begin
                        r_free     <= 1'b1;
                        r_free_idx <= r_pidx;
                    end
                    if (scan_done) begin
                        case (r_mode)
                            M_BUF:   r_state <= S_WRITE;
                            M_SNAP: begin
                                r_mode <= M_EMIT;
                                r_cnt  <= '0;
                                r_hit  <= 1'b0;
                                r_any  <= 1'b0;
                            end
                            default: r_state <= S_EDEC;
                        endcase
                    end
                end
                S_WRITE: begin
                    if (ram_we) begin
                        r_slot_valid[ram_waddr] <= 1'b1;
                    end else begin
                        r_health <= ST_GAP;
                    end
                    r_cnt  <= '0;
                    r_hit  <= 1'b0;
                    r_any  <= 1'b0;
                    r_mode <= M_EMIT;
                    r_state <= r_item.last_in_packet ? S_SCAN : S_STAT;
                end
                S_EDEC: begin
                    if (r_hit) begin
                        if (out_free) begin
                            r_slot_valid[r_hit_idx] <= 1'b0;
                            r_ne <= n_ne;
                            r_out.has_event       <= 1'b1;
                            r_out.out_seq         <= r_hdata.seq;
                            r_out.out_type        <= r_hdata.typ;
                            r_out.out_payload_ref <= r_hdata.pay;
                            r_out.out_channel     <= r_hdata.feed;
                            r_out.last            <= 1'b0;
                            // The gap closes once emission reaches its bound.
                            if (r_health == ST_GAP && r_gap_high != 64'd0
                                    && n_ne >= r_gap_high) begin
                                r_health   <= ST_HEALTHY;
                                r_gap_low  <= '0;
                                r_gap_high <= '0;
                                r_out.feed_state <= ST_HEALTHY;
                                r_out.gap_first  <= '0;
                                r_out.gap_bound  <= '0;
                            end else begin
                                r_out.feed_state <= r_health;
                                r_out.gap_first  <= r_gap_low;
                                r_out.gap_bound  <= r_gap_high;
                            end
                            r_cnt   <= '0;
                            r_hit   <= 1'b0;
                            r_any   <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end else begin
                        if (r_any && r_lo > r_ne) begin
                            r_gap_low  <= r_ne;
                            r_gap_high <= r_lo;
                            r_health   <= ST_GAP;
                        end
                        r_state <= S_STAT;
                    end
                end
                S_STAT: begin
                    if (out_free) begin
                        r_out.has_event       <= 1'b0;
                        r_out.out_seq         <= '0;
                        r_out.out_type        <= '0;
                        r_out.out_payload_ref <= '0;
                        r_out.out_channel     <= 1'b0;
                        r_out.gap_first       <= r_gap_low;
                        r_out.gap_bound       <= r_gap_high;
                        r_out.last            <= 1'b1;
                        // A snapshot leaves the feed healthy unless its emission found a gap.
                        if (r_item.cmd == CMD_SNAPSHOT && r_health != ST_GAP) begin
                            r_health         <= ST_HEALTHY;
                            r_out.feed_state <= ST_HEALTHY;
                        end else begin
                            r_out.feed_state <= r_health;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_recover_only_in_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_health != ST_RECOVER)
        else $error("recover state left over after an item");

    a_accept_starts_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_state == S_CHECK)
        else $error("accepted item did not start the sequencer");

    a_scan_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(SLOTS))
        else $error("slot scan counter overran");
`endif

endmodule

// File: test/testbench.sv
// Self-checking testbench for the dual-feed sequence reorder block.
module testbench import dfsr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Tracks the buffered events and feed health, and holds the results still owed.
    class reorder_scoreboard;
        logic [5:0]  window;
        logic [63:0] next_seq;
        logic [31:0] session;
        logic [1:0]  health;
        logic [63:0] gap_lo;
        logic [63:0] gap_hi;
        bit          slot_on[SLOTS];
        t_slot       slot[SLOTS];
        t_out_item   owed[$];
        int          mismatches;
        int          events_out;
        int          results_seen;

        function new();
            window = WINDOW_RESET;
            next_seq = '0;
            session = '0;
            health = ST_HEALTHY;
            gap_lo = '0;
            gap_hi = '0;
            foreach (slot_on[i]) slot_on[i] = 0;
            mismatches = 0;
            events_out = 0;
            results_seen = 0;
        endfunction

        function void owe(bit ev, int idx, bit fin);
            t_out_item r;
            r = '0;
            r.has_event = ev;
            if (ev) begin
                r.out_seq = slot[idx].seq;
                r.out_type = slot[idx].typ;
                r.out_payload_ref = slot[idx].pay;
                r.out_channel = slot[idx].feed;
            end
            r.feed_state = health;
            r.gap_first = gap_lo;
            r.gap_bound = gap_hi;
            r.last = fin;
            owed = {owed, r};
        endfunction

        function void store_event(t_in_item it);
            int win;
            int pick;
            win = (window < SLOTS) ? int'(window) : SLOTS;
            pick = -1;
            if (next_seq == 0) next_seq = it.event_seq;
            if (it.event_seq < next_seq) return;
            if (it.event_seq - next_seq >= 64'(win)) begin
                health = ST_GAP;
                return;
            end
            for (int i = 0; i < SLOTS && pick < 0; i++)
                if (slot_on[i] && slot[i].seq == it.event_seq) pick = i;
            for (int i = 0; i < SLOTS && pick < 0; i++)
                if (!slot_on[i]) pick = i;
            if (pick < 0) begin
                health = ST_GAP;
                return;
            end
            slot_on[pick] = 1;
            slot[pick].seq = it.event_seq;
            slot[pick].typ = it.event_type;
            slot[pick].pay = it.payload_ref;
            slot[pick].feed = it.channel;
        endfunction

        // Emits buffered events while the next expected one is present.
        function void release_in_order();
            int hit;
            bit any;
            logic [63:0] lo;
            forever begin
                hit = -1;
                any = 0;
                lo = '0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_on[i]) begin
                        if (slot[i].seq == next_seq && hit < 0) hit = i;
                        if (!any || slot[i].seq < lo) lo = slot[i].seq;
                        any = 1;
                    end
                end
                if (hit < 0) begin
                    if (any && lo > next_seq) begin
                        gap_lo = next_seq;
                        gap_hi = lo;
                        health = ST_GAP;
                    end
                    return;
                end
                slot_on[hit] = 0;
                next_seq++;
                if (health == ST_GAP && gap_hi > 0 && next_seq >= gap_hi) begin
                    health = ST_HEALTHY;
                    gap_lo = '0;
                    gap_hi = '0;
                end
                owe(1'b1, hit, 1'b0);
            end
        endfunction

        function void note_input(t_in_item it);
            if (it.cmd == CMD_SNAPSHOT) begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_on[i] && slot[i].seq <= it.event_seq) slot_on[i] = 0;
                next_seq = it.event_seq + 64'd1;
                health = ST_RECOVER;
                release_in_order();
                if (health != ST_GAP) health = ST_HEALTHY;
            end else begin
                if (session == 0) begin
                    session = it.session_id;
                    store_event(it);
                    if (it.last_in_packet) release_in_order();
                end else if (it.session_id != session) begin
                    health = ST_STALE;
                end else begin
                    store_event(it);
                    if (it.last_in_packet) release_in_order();
                end
            end
            owe(1'b0, 0, 1'b1);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            results_seen++;
            if (got.has_event) events_out++;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", got);
                return;
            end
            exp = owed[0];
            owed.delete(0);
            if (got.has_event !== exp.has_event || got.out_seq !== exp.out_seq ||
                got.out_type !== exp.out_type ||
                got.out_payload_ref !== exp.out_payload_ref ||
                got.out_channel !== exp.out_channel ||
                got.feed_state !== exp.feed_state || got.gap_first !== exp.gap_first ||
                got.gap_bound !== exp.gap_bound || got.last !== exp.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result %0d exp %b %h %h %h %b got %b %h %h %h %b",
                             results_seen, exp.has_event, exp.out_seq, exp.out_type,
                             exp.out_payload_ref, exp.out_channel, got.has_event,
                             got.out_seq, got.out_type, got.out_payload_ref,
                             got.out_channel);
                    $display("       state/gap/last exp %0d %h %h %b got %0d %h %h %b",
                             exp.feed_state, exp.gap_first, exp.gap_bound, exp.last,
                             got.feed_state, got.gap_first, got.gap_bound, got.last);
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    t_in_item   i_in_data;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_data;
    logic       i_out_stall;
    logic       i_cfg_we;
    logic [5:0] i_cfg_wdata;

    reorder_scoreboard sb;
    bit          quiet;
    bit          hold_request;
    int          transfers_in;
    int          snapshots_in;
    logic [31:0] feed_session;

    dual_feed_sequence_reorder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #30ms;
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: checks each transfer and stalls in random bursts, and for a long hold on request.
    initial begin
        int stall_left;
        stall_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            if (hold_request) begin
                hold_request = 0;
                stall_left = 3000;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 18);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(t_in_item it);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
        transfers_in++;
        if (it.cmd == CMD_SNAPSHOT) snapshots_in++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);
    endtask

    task automatic write_window(logic [5:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.window = value;
    endtask

    function automatic t_in_item feed_event(logic [31:0] sid, logic [63:0] seq, bit last_ev);
        t_in_item it;
        it.cmd = CMD_EVENT;
        it.session_id = sid;
        it.channel = 1'($urandom_range(0, 1));
        it.event_seq = seq;
        it.event_type = 8'($urandom_range(0, 255));
        it.payload_ref = $urandom;
        it.last_in_packet = last_ev;
        return it;
    endfunction

    function automatic t_in_item snapshot(logic [63:0] seq);
        t_in_item it;
        it = feed_event($urandom, seq, 1'($urandom_range(0, 1)));
        it.cmd = CMD_SNAPSHOT;
        return it;
    endfunction

    // Mostly in-window packets around the next expected sequence, plus noise.
    function automatic t_in_item random_item();
        logic [63:0] base;
        int          pick;
        int          span;
        base = (sb.next_seq == 0) ? {$urandom, $urandom} : sb.next_seq;
        span = (sb.window < SLOTS) ? int'(sb.window) : SLOTS;
        pick = $urandom_range(0, 99);
        if (pick < 2) return snapshot({$urandom, $urandom});
        if (pick < 7) return snapshot(base + 64'($urandom_range(0, 10)) - 64'd2);
        if (pick < 11) return feed_event($urandom, base, 1'($urandom_range(0, 1)));
        if (pick < 15) return feed_event(feed_session, base - 64'($urandom_range(1, 4)), 1'b1);
        if (pick < 19)
            return feed_event(feed_session, base + 64'(span + $urandom_range(0, 6)),
                              1'($urandom_range(0, 1)));
        return feed_event(feed_session, base + 64'($urandom_range(0, span + 1)),
                          $urandom_range(0, 99) < 35);
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) send_item(random_item());
    endtask

    initial begin
        t_in_item it;
        int       limit;
        sb = new();
        quiet = 0;
        hold_request = 0;
        transfers_in = 0;
        snapshots_in = 0;
        feed_session = $urandom | 32'h1;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: session zero, gap and recovery, stale, duplicates, overwrite.
        send_item(feed_event(32'h0, 64'd5, 1'b0));
        it = feed_event(feed_session, 64'd7, 1'b1);
        it.event_type = 8'hFF;
        it.payload_ref = 32'hFFFF_FFFF;
        it.channel = 1'b1;
        send_item(it);
        it = feed_event(feed_session, 64'd6, 1'b1);
        it.event_type = 8'h00;
        it.payload_ref = 32'h0;
        it.channel = 1'b0;
        send_item(it);
        send_item(feed_event(feed_session, 64'd3, 1'b1));
        send_item(feed_event(feed_session, 64'd48, 1'b1));
        send_item(feed_event(feed_session, 64'd10, 1'b0));
        send_item(feed_event(feed_session, 64'd10, 1'b0));
        send_item(feed_event(feed_session, 64'd8, 1'b1));
        send_item(feed_event(~feed_session, 64'd9, 1'b1));
        send_item(feed_event(feed_session, 64'd9, 1'b1));
        send_item(snapshot(64'd20));
        send_item(snapshot(64'hFFFF_FFFF_FFFF_FFFF));
        send_item(feed_event(feed_session, 64'd0, 1'b1));
        send_item(feed_event(feed_session, 64'd0, 1'b1));
        send_item(snapshot(64'hFFFF_FFFF_FFFF_FFF0));
        send_item(feed_event(feed_session, 64'hFFFF_FFFF_FFFF_FFF3, 1'b0));
        send_item(feed_event(feed_session, 64'hFFFF_FFFF_FFFF_FFF1, 1'b1));
        send_item(snapshot(64'hFFFF_FFFF_FFFF_FFF2));
        send_item(snapshot(64'h8000_0000_0000_0000));
        send_item(feed_event(feed_session, 64'h8000_0000_0000_0001, 1'b1));

        write_window(6'd0);
        random_phase(30);
        write_window(6'd1);
        random_phase(60);
        write_window(6'd63);
        hold_request = 1;
        random_phase(90);
        write_window(6'd8);
        random_phase(50);
        // The sender pauses here until every owed result is back.
        wait_drained();
        random_phase(50);
        write_window(6'd32);
        random_phase(90);
        write_window(6'd20);
        quiet = 1;
        random_phase(90);

        i_in_valid <= 1'b0;
        limit = 0;
        while (sb.owed.size() != 0 && limit < 200000) begin
            @(posedge i_clk);
            limit++;
        end
        repeat (SLOTS + 8) @(posedge i_clk);
        $display("Sent %0d items (%0d snapshots) over windows 0, 1, 8, 20, 32 and 63.",
                 transfers_in, snapshots_in);
        $display("Checked %0d results, %0d of them emitted events.",
                 sb.results_seen, sb.events_out);
        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("Failures: %0d, results still owed: %0d", sb.mismatches, sb.owed.size());
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
